/* rtl/core/ppucrp_pkg.sv */
// ----------------------------------------------------------------------------
// ppucrp_pkg
// Shared codes and constants for the video chip CPU register port.
// ----------------------------------------------------------------------------
package ppucrp_pkg;

  localparam int unsigned SpriteMemBytesDefault = 256;

  localparam int unsigned OpWidth   = 3;
  localparam int unsigned RegWidth  = 3;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned AddrWidth = 16;

  typedef logic [OpWidth-1:0]   op_t;
  typedef logic [RegWidth-1:0]  reg_idx_t;
  typedef logic [ByteWidth-1:0] byte_t;
  typedef logic [AddrWidth-1:0] vaddr_t;

  localparam op_t OpWrite       = 3'd0;
  localparam op_t OpRead        = 3'd1;
  localparam op_t OpPeek        = 3'd2;
  localparam op_t OpVblankStart = 3'd3;
  localparam op_t OpFrameStart  = 3'd4;

  localparam reg_idx_t RegControl  = 3'd0;
  localparam reg_idx_t RegMask     = 3'd1;
  localparam reg_idx_t RegStatus   = 3'd2;
  localparam reg_idx_t RegOamAddr  = 3'd3;
  localparam reg_idx_t RegOamData  = 3'd4;
  localparam reg_idx_t RegScroll   = 3'd5;
  localparam reg_idx_t RegAddress  = 3'd6;
  localparam reg_idx_t RegData     = 3'd7;

  localparam vaddr_t PaletteBase = 16'h3F00;
  localparam vaddr_t StepOne     = 16'd1;
  localparam vaddr_t StepRow     = 16'd32;

  typedef struct packed {
    op_t      operation;
    reg_idx_t reg_index;
    byte_t    write_data;
    byte_t    vram_byte;
  } item_t;

  typedef struct packed {
    byte_t  read_data;
    logic   vram_write;
    vaddr_t vram_access_addr;
    byte_t  vram_write_byte;
    vaddr_t next_vram_addr;
    logic   nmi;
  } result_t;

endpackage

/* rtl/core/ppu_cpu_register_port.sv */
// ----------------------------------------------------------------------------
// ppu_cpu_register_port
// CPU side of the video chip register file: control, mask, status, sprite
// memory port, scroll and address latches, and the buffered data port.
// ----------------------------------------------------------------------------
// Usage: each input word is one CPU bus access (write, read, peek) or one
// timing event (vblank start, frame start), together with the video memory
// byte at the current VRAM address. Each input word produces exactly one
// result word carrying the read byte, the VRAM write strobe, address and
// byte, the VRAM address after the step, and the interrupt request.
// Both channels use valid and stall; a word moves on a rising edge with
// valid high and stall low.
// An accepted word is worked on while it sits in the input register, and its
// result is loaded into the result register once that register is free.
// Throughput is one word per cycle while the receiver does not stall, set by
// the single pass of register update logic and the registered sprite memory
// read port.
// When the receiver stalls, the result register holds its word, the input
// register takes one more word, and then in_stall_o rises.
// Reset clears all control and status registers, the latches and both
// pipeline stages. Sprite memory contents are not cleared.
// ----------------------------------------------------------------------------
module ppu_cpu_register_port #(
  parameter int unsigned SPRITE_MEM_BYTES = ppucrp_pkg::SpriteMemBytesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ppucrp_pkg::op_t              operation_i,
  input  ppucrp_pkg::reg_idx_t         reg_index_i,
  input  ppucrp_pkg::byte_t            write_data_i,
  input  ppucrp_pkg::byte_t            vram_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ppucrp_pkg::byte_t            read_data_o,
  output logic                         vram_write_o,
  output ppucrp_pkg::vaddr_t           vram_access_addr_o,
  output ppucrp_pkg::byte_t            vram_write_byte_o,
  output ppucrp_pkg::vaddr_t           next_vram_addr_o,
  output logic                         nmi_o
);
  import ppucrp_pkg::*;

  localparam int unsigned SprAw = $clog2(SPRITE_MEM_BYTES);

  logic    item_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t out_q;
  result_t res_d;
  logic    out_free;
  logic    advance;

  byte_t   control_q, control_d;
  byte_t   mask_q, mask_d;
  byte_t   status_q, status_d;
  byte_t   spr_addr_q, spr_addr_d;
  logic    toggle_q, toggle_d;
  logic [2:0] fine_x_q, fine_x_d;
  vaddr_t  temp_q, temp_d;
  vaddr_t  cur_q, cur_d;
  byte_t   rbuf_q, rbuf_d;

  byte_t   spr_mem [SPRITE_MEM_BYTES];
  byte_t   spr_rd_q;
  logic    spr_we;
  vaddr_t  step;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;

  assign step = control_q[2] ? StepRow : StepOne;

  always_comb begin
    control_d  = control_q;
    mask_d     = mask_q;
    status_d   = status_q;
    spr_addr_d = spr_addr_q;
    toggle_d   = toggle_q;
    fine_x_d   = fine_x_q;
    temp_d     = temp_q;
    cur_d      = cur_q;
    rbuf_d     = rbuf_q;
    spr_we     = 1'b0;
    res_d      = '0;

    unique case (item_q.operation)
      OpWrite: begin
        unique case (item_q.reg_index)
          RegControl: begin
            control_d      = item_q.write_data;
            temp_d[11:10]  = item_q.write_data[1:0];
          end
          RegMask: begin
            mask_d = item_q.write_data;
          end
          RegOamAddr: begin
            spr_addr_d = item_q.write_data;
          end
          RegOamData: begin
            spr_we = 1'b1;
          end
          RegScroll: begin
            if (!toggle_q) begin
              fine_x_d    = item_q.write_data[2:0];
              temp_d[4:0] = item_q.write_data[7:3];
              toggle_d    = 1'b1;
            end else begin
              temp_d[14:12] = item_q.write_data[2:0];
              temp_d[9:5]   = item_q.write_data[7:3];
              toggle_d      = 1'b0;
            end
          end
          RegAddress: begin
            if (!toggle_q) begin
              temp_d[15:8] = {2'b00, item_q.write_data[5:0]};
              toggle_d     = 1'b1;
            end else begin
              temp_d[7:0] = item_q.write_data;
              cur_d       = {temp_q[15:8], item_q.write_data};
              toggle_d    = 1'b0;
            end
          end
          RegData: begin
            res_d.vram_write       = 1'b1;
            res_d.vram_access_addr = cur_q;
            res_d.vram_write_byte  = item_q.write_data;
            cur_d                  = cur_q + step;
          end
          default: begin
          end
        endcase
      end
      OpRead: begin
        unique case (item_q.reg_index)
          RegStatus: begin
            res_d.read_data = {status_q[7:5], rbuf_q[4:0]};
            status_d[7]     = 1'b0;
            toggle_d        = 1'b0;
          end
          RegOamData: begin
            res_d.read_data = spr_rd_q;
          end
          RegData: begin
            res_d.vram_access_addr = cur_q;
            res_d.read_data = (cur_q >= PaletteBase) ? item_q.vram_byte : rbuf_q;
            rbuf_d          = item_q.vram_byte;
            cur_d           = cur_q + step;
          end
          default: begin
          end
        endcase
      end
      OpPeek: begin
        unique case (item_q.reg_index)
          RegControl: res_d.read_data = control_q;
          RegMask:    res_d.read_data = mask_q;
          RegStatus:  res_d.read_data = status_q;
          default:    res_d.read_data = '0;
        endcase
      end
      OpVblankStart: begin
        status_d[7] = 1'b1;
        res_d.nmi   = control_q[7];
      end
      OpFrameStart: begin
        status_d[7:5] = 3'b000;
      end
      default: begin
      end
    endcase

    res_d.next_vram_addr = cur_d;
  end

  always_ff @(posedge clk_i) begin
    if (advance && spr_we) begin
      spr_mem[spr_addr_q[SprAw-1:0]] <= item_q.write_data;
    end
    if (advance && spr_we) begin
      spr_rd_q <= item_q.write_data;
    end else if (advance) begin
      spr_rd_q <= spr_mem[spr_addr_d[SprAw-1:0]];
    end else begin
      spr_rd_q <= spr_mem[spr_addr_q[SprAw-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      control_q    <= '0;
      mask_q       <= '0;
      status_q     <= '0;
      spr_addr_q   <= '0;
      toggle_q     <= 1'b0;
      fine_x_q     <= '0;
      temp_q       <= '0;
      cur_q        <= '0;
      rbuf_q       <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        control_q   <= control_d;
        mask_q      <= mask_d;
        status_q    <= status_d;
        spr_addr_q  <= spr_addr_d;
        toggle_q    <= toggle_d;
        fine_x_q    <= fine_x_d;
        temp_q      <= temp_d;
        cur_q       <= cur_d;
        rbuf_q      <= rbuf_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.operation  <= operation_i;
      item_q.reg_index  <= reg_index_i;
      item_q.write_data <= write_data_i;
      item_q.vram_byte  <= vram_byte_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign read_data_o        = out_q.read_data;
  assign vram_write_o       = out_q.vram_write;
  assign vram_access_addr_o = out_q.vram_access_addr;
  assign vram_write_byte_o  = out_q.vram_write_byte;
  assign next_vram_addr_o   = out_q.next_vram_addr;
  assign nmi_o              = out_q.nmi;

endmodule

/* bench/ppu_cpu_register_port_test.sv */
// ----------------------------------------------------------------------------
// ppu_cpu_register_port_test
// Self-checking bench for the video chip CPU register port. A short table of
// directed words covers reset values, register extremes, events, ignored
// accesses and the buffered data port; random bus traffic and a data port
// sweep in steps of 32 upward from the palette base follow. Every result word
// is checked field by field against a fixed expected word or a predictor
// kept inside the bench, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module ppu_cpu_register_port_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ppucrp_pkg::*;

  localparam op_t OpSpareLow = 3'd5;
  localparam op_t OpSpareMid = 3'd6;
  localparam op_t OpSpareTop = 3'd7;

  typedef struct {
    item_t   word;
    bit      golden;
    result_t want;
  } row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  op_t      operation_i;
  reg_idx_t reg_index_i;
  byte_t    write_data_i;
  byte_t    vram_byte_i;
  logic     out_valid_o;
  logic     out_stall_i;
  byte_t    read_data_o;
  logic     vram_write_o;
  vaddr_t   vram_access_addr_o;
  byte_t    vram_write_byte_o;
  vaddr_t   next_vram_addr_o;
  logic     nmi_o;

  byte_t   ctrl_q;
  byte_t   mask_q;
  byte_t   stat_q;
  byte_t   oam_addr_q;
  byte_t   oam_bytes [SpriteMemBytesDefault];
  bit      oam_seen [SpriteMemBytesDefault];
  bit      toggle_q;
  vaddr_t  t_addr;
  vaddr_t  v_addr;
  byte_t   rbuf_q;

  result_t pending_results [$];
  row_t    script [$];
  int      failures;
  int      words_sent;
  bit      flood;
  bit      squeeze_done;

  ppu_cpu_register_port i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .reg_index_i        (reg_index_i),
    .write_data_i       (write_data_i),
    .vram_byte_i        (vram_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_data_o        (read_data_o),
    .vram_write_o       (vram_write_o),
    .vram_access_addr_o (vram_access_addr_o),
    .vram_write_byte_o  (vram_write_byte_o),
    .next_vram_addr_o   (next_vram_addr_o),
    .nmi_o              (nmi_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL ppu_cpu_register_port");
    $finish;
  end

  function automatic result_t port_respond(input item_t w);
    result_t r;
    vaddr_t  step;
    r = '0;
    step = ctrl_q[2] ? StepRow : StepOne;
    case (w.operation)
      OpWrite: begin
        case (w.reg_index)
          RegControl: begin
            ctrl_q = w.write_data;
            t_addr[11:10] = w.write_data[1:0];
          end
          RegMask: mask_q = w.write_data;
          RegOamAddr: oam_addr_q = w.write_data;
          RegOamData: begin
            oam_bytes[oam_addr_q] = w.write_data;
            oam_seen[oam_addr_q] = 1'b1;
          end
          RegScroll: begin
            if (!toggle_q) begin
              t_addr[4:0] = w.write_data[7:3];
            end else begin
              t_addr[14:12] = w.write_data[2:0];
              t_addr[9:5] = w.write_data[7:3];
            end
            toggle_q = ~toggle_q;
          end
          RegAddress: begin
            if (!toggle_q) begin
              t_addr[15:8] = {2'b00, w.write_data[5:0]};
            end else begin
              t_addr[7:0] = w.write_data;
              v_addr = t_addr;
            end
            toggle_q = ~toggle_q;
          end
          RegData: begin
            r.vram_write = 1'b1;
            r.vram_access_addr = v_addr;
            r.vram_write_byte = w.write_data;
            v_addr = v_addr + step;
          end
          default: ;
        endcase
      end
      OpRead: begin
        case (w.reg_index)
          RegStatus: begin
            r.read_data = {stat_q[7:5], rbuf_q[4:0]};
            stat_q[7] = 1'b0;
            toggle_q = 1'b0;
          end
          RegOamData: r.read_data = oam_bytes[oam_addr_q];
          RegData: begin
            r.vram_access_addr = v_addr;
            r.read_data = (v_addr >= PaletteBase) ? w.vram_byte : rbuf_q;
            rbuf_q = w.vram_byte;
            v_addr = v_addr + step;
          end
          default: ;
        endcase
      end
      OpPeek: begin
        if (w.reg_index == RegControl) r.read_data = ctrl_q;
        else if (w.reg_index == RegMask) r.read_data = mask_q;
        else if (w.reg_index == RegStatus) r.read_data = stat_q;
      end
      OpVblankStart: begin
        stat_q[7] = 1'b1;
        r.nmi = ctrl_q[7];
      end
      OpFrameStart: stat_q[7:5] = 3'b000;
      default: ;
    endcase
    r.next_vram_addr = v_addr;
    return r;
  endfunction

  function automatic item_t mk(input op_t op, input reg_idx_t idx, input byte_t wd,
                               input byte_t vb);
    item_t w;
    w.operation = op;
    w.reg_index = idx;
    w.write_data = wd;
    w.vram_byte = vb;
    return w;
  endfunction

  function automatic result_t quiet(input byte_t rd, input vaddr_t nxt, input logic irq);
    result_t r;
    r = '0;
    r.read_data = rd;
    r.next_vram_addr = nxt;
    r.nmi = irq;
    return r;
  endfunction

  function automatic byte_t rb();
    return byte_t'($urandom);
  endfunction

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_row(input item_t w, input bit golden = 1'b0, input result_t want = '0);
    row_t r;
    r.word = w;
    r.golden = golden;
    r.want = want;
    script.push_back(r);
  endtask

  task automatic offer(input item_t w, input bit golden = 1'b0, input result_t want = '0);
    int gap;
    gap = flood ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= w.operation;
    reg_index_i <= w.reg_index;
    write_data_i <= w.write_data;
    vram_byte_i <= w.vram_byte;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (golden) begin
      void'(port_respond(w));
      pending_results.push_back(want);
    end else begin
      pending_results.push_back(port_respond(w));
    end
    words_sent++;
  endtask

  task automatic data_access();
    offer(mk($urandom_range(0, 1) ? OpWrite : OpRead, RegData, rb(), rb()));
  endtask

  task automatic random_traffic(input int count);
    int       roll;
    int       stop_at;
    reg_idx_t idx;
    stop_at = words_sent + count;
    flood = 1'b1;
    while (words_sent < stop_at) begin
      if (words_sent > stop_at - count + 80) flood = 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        if (toggle_q && $urandom_range(0, 1)) offer(mk(OpRead, RegStatus, rb(), rb()));
        offer(mk(OpWrite, RegAddress, rb(), rb()));
        offer(mk(OpWrite, RegAddress, rb(), rb()));
        repeat ($urandom_range(1, 6)) data_access();
      end else if (roll < 25) begin
        offer(mk(OpWrite, RegScroll, rb(), rb()));
      end else if (roll < 35) begin
        data_access();
      end else if (roll < 45) begin
        roll = $urandom_range(0, 2);
        if (roll == 0) offer(mk(OpWrite, RegOamAddr, rb(), rb()));
        else if (roll == 1 || !oam_seen[oam_addr_q]) offer(mk(OpWrite, RegOamData, rb(), rb()));
        else offer(mk(OpRead, RegOamData, rb(), rb()));
      end else if (roll < 53) begin
        offer(mk(OpWrite, RegControl, rb(), rb()));
      end else if (roll < 58) begin
        offer(mk(OpWrite, RegMask, rb(), rb()));
      end else if (roll < 66) begin
        offer(mk(OpRead, RegStatus, rb(), rb()));
      end else if (roll < 74) begin
        offer(mk($urandom_range(0, 1) ? OpVblankStart : OpFrameStart,
                 reg_idx_t'($urandom), rb(), rb()));
      end else if (roll < 82) begin
        offer(mk(OpPeek, reg_idx_t'($urandom), rb(), rb()));
      end else if (roll < 90) begin
        idx = reg_idx_t'($urandom);
        if (idx == RegOamData && !oam_seen[oam_addr_q]) idx = RegMask;
        offer(mk(OpRead, idx, rb(), rb()));
      end else if (roll < 96) begin
        offer(mk(OpWrite, reg_idx_t'($urandom), rb(), rb()));
      end else begin
        offer(mk(op_t'($urandom_range(OpSpareLow, OpSpareTop)), reg_idx_t'($urandom),
                 rb(), rb()));
      end
    end
    flood = 1'b0;
  endtask

  task automatic check_word();
    result_t got;
    result_t want;
    got.read_data = read_data_o;
    got.vram_write = vram_write_o;
    got.vram_access_addr = vram_access_addr_o;
    got.vram_write_byte = vram_write_byte_o;
    got.next_vram_addr = next_vram_addr_o;
    got.nmi = nmi_o;
    if (pending_results.size() == 0) begin
      failures++;
      if (failures <= 10) $display("unexpected result word at %0t", $realtime);
    end else begin
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data || got.vram_write !== want.vram_write ||
          got.vram_access_addr !== want.vram_access_addr ||
          got.vram_write_byte !== want.vram_write_byte ||
          got.next_vram_addr !== want.next_vram_addr || got.nmi !== want.nmi) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch at %0t: expected rd=%h vw=%b acc=%h wb=%h next=%h nmi=%b",
                   $realtime, want.read_data, want.vram_write, want.vram_access_addr,
                   want.vram_write_byte, want.next_vram_addr, want.nmi);
          $display("                 got      rd=%h vw=%b acc=%h wb=%h next=%h nmi=%b",
                   got.read_data, got.vram_write, got.vram_access_addr,
                   got.vram_write_byte, got.next_vram_addr, got.nmi);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_word();
  end

  initial begin
    bit hold;
    int run;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (flood && !squeeze_done) begin
        hold = 1'b1;
        run = 64;
        squeeze_done = 1'b1;
      end else begin
        run = $urandom_range(0, 9);
        hold = (run >= 5);
        if (run < 5) run = $urandom_range(1, 20);
        else if (run < 9) run = $urandom_range(1, 3);
        else run = $urandom_range(8, 30);
      end
      @(negedge clk_i);
      out_stall_i <= hold;
      repeat (run - 1) @(negedge clk_i);
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OpPeek;
    reg_index_i = RegControl;
    write_data_i = '0;
    vram_byte_i = '0;
    failures = 0;
    words_sent = 0;
    flood = 1'b0;
    squeeze_done = 1'b0;
    ctrl_q = '0;
    mask_q = '0;
    stat_q = '0;
    oam_addr_q = '0;
    toggle_q = 1'b0;
    t_addr = '0;
    v_addr = '0;
    rbuf_q = '0;
    foreach (oam_seen[k]) begin
      oam_seen[k] = 1'b0;
      oam_bytes[k] = '0;
    end

    add_row(mk(OpPeek, RegControl, 8'hFF, 8'hFF), 1'b1, quiet(8'h00, 16'h0000, 1'b0));
    add_row(mk(OpRead, RegStatus, 8'h00, 8'h00), 1'b1, quiet(8'h00, 16'h0000, 1'b0));
    add_row(mk(OpWrite, RegControl, 8'hFF, 8'h00), 1'b1, quiet(8'h00, 16'h0000, 1'b0));
    add_row(mk(OpPeek, RegControl, 8'h00, 8'h00), 1'b1, quiet(8'hFF, 16'h0000, 1'b0));
    add_row(mk(OpWrite, RegMask, 8'hFF, 8'h00), 1'b1, quiet(8'h00, 16'h0000, 1'b0));
    add_row(mk(OpPeek, RegMask, 8'h00, 8'h00), 1'b1, quiet(8'hFF, 16'h0000, 1'b0));
    add_row(mk(OpVblankStart, RegData, 8'h00, 8'h00), 1'b1, quiet(8'h00, 16'h0000, 1'b1));
    add_row(mk(OpPeek, RegStatus, 8'h00, 8'h00), 1'b1, quiet(8'h80, 16'h0000, 1'b0));
    add_row(mk(OpRead, RegStatus, 8'h00, 8'h00), 1'b1, quiet(8'h80, 16'h0000, 1'b0));
    add_row(mk(OpPeek, RegStatus, 8'h00, 8'h00), 1'b1, quiet(8'h00, 16'h0000, 1'b0));
    add_row(mk(OpVblankStart, RegControl, 8'hFF, 8'hFF), 1'b1, quiet(8'h00, 16'h0000, 1'b1));
    add_row(mk(OpFrameStart, RegStatus, 8'h00, 8'h00), 1'b1, quiet(8'h00, 16'h0000, 1'b0));
    add_row(mk(OpWrite, RegStatus, 8'hFF, 8'hFF), 1'b1, quiet(8'h00, 16'h0000, 1'b0));
    add_row(mk(OpRead, RegMask, 8'h00, 8'h00), 1'b1, quiet(8'h00, 16'h0000, 1'b0));
    add_row(mk(OpSpareTop, RegData, 8'hFF, 8'hFF), 1'b1, quiet(8'h00, 16'h0000, 1'b0));
    add_row(mk(OpSpareLow, RegControl, 8'h00, 8'h00), 1'b1, quiet(8'h00, 16'h0000, 1'b0));
    add_row(mk(OpSpareMid, RegOamAddr, 8'hA5, 8'h5A), 1'b1, quiet(8'h00, 16'h0000, 1'b0));
    add_row(mk(OpWrite, RegControl, 8'h00, 8'h00));
    add_row(mk(OpVblankStart, RegMask, 8'h00, 8'h00), 1'b1, quiet(8'h00, 16'h0000, 1'b0));
    add_row(mk(OpWrite, RegOamAddr, 8'hFF, 8'h00));
    add_row(mk(OpWrite, RegOamData, 8'hA5, 8'h00));
    add_row(mk(OpRead, RegOamData, 8'h00, 8'h00), 1'b1, quiet(8'hA5, 16'h0000, 1'b0));
    add_row(mk(OpWrite, RegScroll, 8'hFF, 8'h00));
    add_row(mk(OpWrite, RegScroll, 8'h00, 8'h00));
    add_row(mk(OpWrite, RegAddress, 8'hFF, 8'h00));
    add_row(mk(OpWrite, RegAddress, 8'h00, 8'h00));
    add_row(mk(OpWrite, RegData, 8'h5A, 8'h00));
    add_row(mk(OpRead, RegData, 8'h00, 8'hC3));
    add_row(mk(OpWrite, RegAddress, 8'h00, 8'h00));
    add_row(mk(OpWrite, RegAddress, 8'hFF, 8'h00));
    add_row(mk(OpRead, RegData, 8'h00, 8'h77));
    add_row(mk(OpRead, RegData, 8'h00, 8'h00));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[k]) offer(script[k].word, script[k].golden, script[k].want);

    random_traffic(600);

    // Step by 32 upward from the palette base.
    offer(mk(OpRead, RegStatus, rb(), rb()));
    offer(mk(OpWrite, RegControl, rb() | 8'h04, rb()));
    offer(mk(OpWrite, RegAddress, 8'h3F, rb()));
    offer(mk(OpWrite, RegAddress, 8'h00, rb()));
    repeat (64) data_access();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS ppu_cpu_register_port");
    end else begin
      $display("FAIL ppu_cpu_register_port");
    end
    $finish;
  end

endmodule
